### hdl/ten_minute_ohlc_bar_aggregator_unit_macros.svh
// Assertion macros for the ten-minute OHLC bar aggregator.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef TEN_MINUTE_OHLC_BAR_AGGREGATOR_UNIT_MACROS_SVH
`define TEN_MINUTE_OHLC_BAR_AGGREGATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TMOA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tmoa_pkg.sv
// Shared types and constants for the ten-minute OHLC bar aggregator.
// No dependencies.
package tmoa_pkg;

  localparam int INST_COUNT = 256;
  localparam int INST_BITS  = 8;
  localparam int DAY_BITS   = 16;
  localparam int SLOT_BITS  = 8;
  localparam int PRICE_BITS = 32;
  localparam int VOL_BITS   = 40;
  localparam int DELTA_BITS = VOL_BITS + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } tmoa_state_t;

  typedef struct packed {
    logic [INST_BITS-1:0]  instrument;
    logic [DAY_BITS-1:0]   trade_day;
    logic [SLOT_BITS-1:0]  slot;
    logic [PRICE_BITS-1:0] last_price;
    logic [VOL_BITS-1:0]   cum_volume;
    logic [VOL_BITS-1:0]   open_interest;
  } tick_t;

  typedef struct packed {
    logic [DAY_BITS-1:0]   day;
    logic [SLOT_BITS-1:0]  slot;
    logic [PRICE_BITS-1:0] open;
    logic [PRICE_BITS-1:0] high;
    logic [PRICE_BITS-1:0] low;
    logic [PRICE_BITS-1:0] close;
    logic [VOL_BITS-1:0]   volume;
    logic [VOL_BITS-1:0]   interest;
  } bar_rec_t;

  typedef struct packed {
    logic [VOL_BITS-1:0] volume;
    logic [VOL_BITS-1:0] interest;
  } prior_rec_t;

  typedef struct packed {
    logic active;
    logic prior_valid;
  } entry_flags_t;

  typedef struct packed {
    entry_flags_t flags;
    prior_rec_t   prior;
  } meta_rec_t;

  typedef struct packed {
    logic hit;
    logic close;
    logic emit;
  } calc_ctrl_t;

endpackage

### hdl/tmoa_bar_calc.sv
// Bar update logic: merges one tick into the stored bar of its instrument, or opens a fresh bar from it.
// Depends on tmoa_pkg.
module tmoa_bar_calc
  import tmoa_pkg::*;
(
  input  tick_t                  tick,
  input  bar_rec_t               cur,
  input  prior_rec_t             prior,
  input  entry_flags_t           flags,
  output bar_rec_t               nxt,
  output calc_ctrl_t             ctrl,
  output logic signed [DELTA_BITS-1:0] vol_delta,
  output logic signed [DELTA_BITS-1:0] oi_delta
);

  always_comb begin
    ctrl.hit   = flags.active && (cur.day == tick.trade_day) && (cur.slot == tick.slot);
    ctrl.close = flags.active && !ctrl.hit;
    ctrl.emit  = ctrl.close && flags.prior_valid;

    if (ctrl.hit) begin
      nxt.day   = cur.day;
      nxt.slot  = cur.slot;
      nxt.open  = cur.open;
      nxt.high  = (cur.high < tick.last_price) ? tick.last_price : cur.high;
      nxt.low   = (cur.low > tick.last_price) ? tick.last_price : cur.low;
      nxt.close = tick.last_price;
    end else begin
      // open a fresh bar from this tick
      nxt.day   = tick.trade_day;
      nxt.slot  = tick.slot;
      nxt.open  = tick.last_price;
      nxt.high  = tick.last_price;
      nxt.low   = tick.last_price;
      nxt.close = tick.last_price;
    end
    nxt.volume   = tick.cum_volume;
    nxt.interest = tick.open_interest;

    vol_delta = $signed({1'b0, cur.volume} - {1'b0, prior.volume});
    oi_delta  = $signed({1'b0, cur.interest} - {1'b0, prior.interest});
  end

endmodule

### hdl/ten_minute_ohlc_bar_aggregator_unit.sv
// Top level of the ten-minute OHLC bar aggregator.
// Depends on tmoa_pkg, tmoa_bar_calc and ten_minute_ohlc_bar_aggregator_unit_macros.svh.
//
//  channel   handshake         payload
//  -------   ---------------   ---------------------------------------------------
//  tick in   start / busy      instrument, trade_day, slot, last_price,
//                              cum_volume, open_interest
//  bar out   bar_valid strobe  bar_instrument, bar_day, bar_slot, bar_open,
//                              bar_close, bar_high, bar_low, volume_delta,
//                              interest_delta
//
// An accepted item reads the bar memory, then is modified and written back while
// busy is high, so no new item is taken until the write-back is done. A closed
// bar whose instrument has a prior reference appears on the outputs for one cycle
// right after the write. After reset a clearing pass zeroes the flag memory, one
// entry a cycle, with busy high until done. The receiver cannot stall the outputs.
`include "ten_minute_ohlc_bar_aggregator_unit_macros.svh"

module ten_minute_ohlc_bar_aggregator_unit
  import tmoa_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [INST_BITS-1:0]         instrument,
  input  logic [DAY_BITS-1:0]          trade_day,
  input  logic [SLOT_BITS-1:0]         slot,
  input  logic [PRICE_BITS-1:0]        last_price,
  input  logic [VOL_BITS-1:0]          cum_volume,
  input  logic [VOL_BITS-1:0]          open_interest,
  output logic                         bar_valid,
  output logic [INST_BITS-1:0]         bar_instrument,
  output logic [DAY_BITS-1:0]          bar_day,
  output logic [SLOT_BITS-1:0]         bar_slot,
  output logic [PRICE_BITS-1:0]        bar_open,
  output logic [PRICE_BITS-1:0]        bar_close,
  output logic [PRICE_BITS-1:0]        bar_high,
  output logic [PRICE_BITS-1:0]        bar_low,
  output logic signed [DELTA_BITS-1:0] volume_delta,
  output logic signed [DELTA_BITS-1:0] interest_delta
);

  tmoa_state_t state, state_next;
  logic        accept;
  logic [INST_BITS-1:0] clr_idx;

  bar_rec_t    bar_mem   [INST_COUNT];
  meta_rec_t   meta_mem  [INST_COUNT];

  tick_t        tick_q;
  logic         inst_ok;
  bar_rec_t     bar_rd;
  meta_rec_t    meta_rd;
  meta_rec_t    meta_wr;
  prior_rec_t   prior_rd;
  entry_flags_t flags;

  bar_rec_t     bar_nxt;
  calc_ctrl_t   ctrl;
  logic signed [DELTA_BITS-1:0] vol_delta;
  logic signed [DELTA_BITS-1:0] oi_delta;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + INST_BITS'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == INST_BITS'(INST_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_CALC;
      end
      ST_CALC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    busy = (state != ST_IDLE);
  end

  // capture the item and read its instrument's entries
  always_ff @(posedge clk) begin
    if (accept) begin
      tick_q   <= '{instrument, trade_day, slot, last_price, cum_volume, open_interest};
      inst_ok  <= ({1'b0, instrument} < INST_COUNT[INST_BITS:0]);
      bar_rd   <= bar_mem[instrument];
      meta_rd  <= meta_mem[instrument];
    end
  end

  assign flags    = meta_rd.flags;
  assign prior_rd = meta_rd.prior;

  tmoa_bar_calc u_calc (
    .tick      (tick_q),
    .cur       (bar_rd),
    .prior     (prior_rd),
    .flags     (flags),
    .nxt       (bar_nxt),
    .ctrl      (ctrl),
    .vol_delta (vol_delta),
    .oi_delta  (oi_delta)
  );

  // closing a bar makes its raw values the new reference
  always_comb begin
    meta_wr.flags.active      = 1'b1;
    meta_wr.flags.prior_valid = flags.prior_valid | ctrl.close;
    if (ctrl.close) begin
      meta_wr.prior.volume   = bar_rd.volume;
      meta_wr.prior.interest = bar_rd.interest;
    end else begin
      meta_wr.prior = prior_rd;
    end
  end

  // write back
  always_ff @(posedge clk) begin
    if (state == ST_CALC && inst_ok) begin
      bar_mem[tick_q.instrument] <= bar_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      meta_mem[clr_idx] <= '0;
    end else if (state == ST_CALC && inst_ok) begin
      meta_mem[tick_q.instrument] <= meta_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_valid <= 1'b0;
    end else begin
      bar_valid <= (state == ST_CALC) && inst_ok && ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC && ctrl.emit) begin
      bar_instrument <= tick_q.instrument;
      bar_day        <= bar_rd.day;
      bar_slot       <= bar_rd.slot;
      bar_open       <= bar_rd.open;
      bar_close      <= bar_rd.close;
      bar_high       <= bar_rd.high;
      bar_low        <= bar_rd.low;
      volume_delta   <= vol_delta;
      interest_delta <= oi_delta;
    end
  end

  `TMOA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
  `TMOA_ASSERT_SAME(a_strobe_src, bar_valid, $past(state == ST_CALC), "bar strobe without write-back")
  `TMOA_ASSERT_SAME(a_strobe_single, bar_valid, !$past(bar_valid), "bar strobe held two cycles")
  `TMOA_ASSERT_SAME(a_emit_closes, (state == ST_CALC) && ctrl.emit, flags.active && !ctrl.hit, "bar emitted without closing")

endmodule
